>>> src/pcs_pkg.sv
package pcs_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned DT_W     = 16;
	localparam int unsigned LIMIT_W  = 31;
	localparam int unsigned PROD_W   = 64;
	localparam int unsigned MUL_W    = 33;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;

	// quotient bits retired per divider cycle
	localparam int unsigned DIV_DIGIT = 4;
	localparam int unsigned DIV_STEPS = PROD_W / DIV_DIGIT;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P         = 3'd0,
		CFG_GAIN_I         = 3'd1,
		CFG_GAIN_D         = 3'd2,
		CFG_INTEGRAL_LIMIT = 3'd3,
		CFG_OUTPUT_LIMIT   = 3'd4,
		CFG_DERIV_MEAS     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> src/pid_controller_step_top.sv
// sequencer steps: accept, P, GI, GD, HI, LO, INT, DIVW (waits on the divider), SUM, FIN;
// a zero step_time goes from accept straight to FIN; one word is worked on at a time, and the
// radix-16 divider for the derivative term sets the pace, the 33x33 multiplier runs alongside
// a new word is taken once the previous drive word is in the output register; the sequencer
// stalls while that register still holds a word that has not been taken
// reset clears gains, limits, integral, previous error and sensed values and held drive
module pid_controller_step_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [pcs_pkg::DATA_W-1:0]    target,
	input  logic signed [pcs_pkg::DATA_W-1:0]    sensed,
	input  logic        [pcs_pkg::DT_W-1:0]      step_time,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pcs_pkg::DATA_W-1:0]    drive,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [pcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [pcs_pkg::DATA_W-1:0]    cfg_data
);
	import pcs_pkg::*;

	localparam int unsigned HI_W = PROD_W - FRAC_W;

	typedef enum logic [3:0] {
		S_IDLE, S_P, S_GI, S_GD, S_HI, S_LO, S_INT, S_DIVW, S_SUM, S_FIN
	} state_t;

	state_t state_q;

	logic signed [DATA_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic        [LIMIT_W-1:0] integral_limit_q, output_limit_q;
	logic                      deriv_meas_q;

	logic signed [DATA_W-1:0]  integral_q, prev_err_q, prev_sensed_q, held_drive_q;
	logic signed [DATA_W-1:0]  sensed_q, err_q, delta_q;
	logic        [DT_W-1:0]    dt_q;
	logic signed [HI_W-1:0]    p_q, gie_q;
	logic signed [PROD_W-1:0]  inc_hi_q, d_q;
	logic                      neg_q;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  drive_q;
	logic                      fin_fire;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic                      div_start;
	logic        [PROD_W-1:0]  div_num, quot;
	div_stat_t                 div_st;

	logic signed [PROD_W-1:0]  inc, int_sum, lim_i, d_val, out_sum, lim_o;
	logic signed [DATA_W-1:0]  err_in, delta_nxt;

	function automatic logic signed [DATA_W-1:0] sat_diff(
		input logic signed [DATA_W-1:0] x,
		input logic signed [DATA_W-1:0] y
	);
		logic signed [DATA_W:0] s;
		s = {x[DATA_W-1], x} - {y[DATA_W-1], y};
		if (s[DATA_W] != s[DATA_W-1])
			return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		return s[DATA_W-1:0];
	endfunction

	function automatic logic signed [PROD_W-1:0] clamp_sym(
		input logic signed [PROD_W-1:0] x,
		input logic signed [PROD_W-1:0] lim
	);
		if (x > lim)
			return lim;
		if (x < -lim)
			return -lim;
		return x;
	endfunction

	pcs_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	pcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_num),
		.denom  (dt_q),
		.quot   (quot),
		.stat   (div_st)
	);

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_P: begin
				mul_a = MUL_W'(gain_p_q);
				mul_b = MUL_W'(err_q);
			end
			S_GI: begin
				mul_a = MUL_W'(gain_i_q);
				mul_b = MUL_W'(err_q);
			end
			S_GD: begin
				mul_a = MUL_W'(gain_d_q);
				mul_b = MUL_W'(delta_q);
			end
			S_HI: begin
				mul_a = MUL_W'($signed(gie_q[HI_W-1:FRAC_W]));
				mul_b = $signed({{(MUL_W-DT_W){1'b0}}, dt_q});
			end
			S_LO: begin
				mul_a = $signed({{(MUL_W-FRAC_W){1'b0}}, gie_q[FRAC_W-1:0]});
				mul_b = $signed({{(MUL_W-DT_W){1'b0}}, dt_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// derivative product arrives in S_HI; divide its magnitude
	assign div_start = (state_q == S_HI);
	assign div_num   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

	assign err_in    = sat_diff(target, sensed);
	assign delta_nxt = deriv_meas_q ? sat_diff(prev_sensed_q, sensed_q)
	                                : sat_diff(err_q, prev_err_q);

	// low partial product is non-negative, so its floor is a plain shift
	assign inc     = inc_hi_q + $signed({{(PROD_W-FRAC_W){1'b0}}, prod[2*FRAC_W-1:FRAC_W]});
	assign int_sum = PROD_W'(integral_q) + inc;
	assign lim_i   = $signed({{(PROD_W-LIMIT_W){1'b0}}, integral_limit_q});
	assign d_val   = neg_q ? -$signed(quot) : $signed(quot);
	assign out_sum = PROD_W'(p_q) + PROD_W'(integral_q) + d_q;
	assign lim_o   = $signed({{(PROD_W-LIMIT_W){1'b0}}, output_limit_q});

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// result moves to the output register when that register is free or being emptied
	assign fin_fire = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q         <= '0;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			integral_limit_q <= '0;
			output_limit_q   <= '0;
			deriv_meas_q     <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GAIN_P:         gain_p_q         <= cfg_data;
				CFG_GAIN_I:         gain_i_q         <= cfg_data;
				CFG_GAIN_D:         gain_d_q         <= cfg_data;
				CFG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_OUTPUT_LIMIT:   output_limit_q   <= cfg_data[LIMIT_W-1:0];
				CFG_DERIV_MEAS:     deriv_meas_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			integral_q    <= '0;
			prev_err_q    <= '0;
			prev_sensed_q <= '0;
			held_drive_q  <= '0;
			out_valid_q   <= 1'b0;
			sensed_q      <= '0;
			dt_q          <= '0;
			err_q         <= '0;
			delta_q       <= '0;
			p_q           <= '0;
			gie_q         <= '0;
			neg_q         <= 1'b0;
			inc_hi_q      <= '0;
			d_q           <= '0;
			drive_q       <= '0;
		end else begin
			if (fin_fire)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sensed_q <= sensed;
						dt_q     <= step_time;
						err_q    <= err_in;
						// zero time step just repeats the held drive
						state_q  <= (step_time == '0) ? S_FIN : S_P;
					end
				end
				S_P: begin
					delta_q <= delta_nxt;
					state_q <= S_GI;
				end
				S_GI: begin
					p_q     <= prod[PROD_W-1:FRAC_W];
					state_q <= S_GD;
				end
				S_GD: begin
					gie_q   <= prod[PROD_W-1:FRAC_W];
					state_q <= S_HI;
				end
				S_HI: begin
					neg_q   <= prod[PROD_W-1];
					state_q <= S_LO;
				end
				S_LO: begin
					inc_hi_q <= prod;
					state_q  <= S_INT;
				end
				S_INT: begin
					integral_q <= DATA_W'(clamp_sym(int_sum, lim_i));
					state_q    <= S_DIVW;
				end
				S_DIVW: begin
					if (div_st.done && !div_st.busy) begin
						d_q     <= d_val;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					held_drive_q <= DATA_W'(clamp_sym(out_sum, lim_o));
					if (deriv_meas_q)
						prev_sensed_q <= sensed_q;
					else
						prev_err_q <= err_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_fire) begin
						drive_q <= held_drive_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule

>>> src/pcs_mul.sv
module pcs_mul (
	input  logic                                clk,
	input  logic signed [pcs_pkg::MUL_W-1:0]    a,
	input  logic signed [pcs_pkg::MUL_W-1:0]    b,
	output logic signed [pcs_pkg::PROD_W-1:0]   prod
);
	import pcs_pkg::*;

	logic signed [2*MUL_W-1:0] full;

	assign full = a * b;

	// every product the sequencer asks for fits in the low 64 bits
	always_ff @(posedge clk) begin
		prod <= full[PROD_W-1:0];
	end

endmodule

>>> src/pcs_div.sv
module pcs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pcs_pkg::PROD_W-1:0]    numer,
	input  logic [pcs_pkg::DT_W-1:0]      denom,
	output logic [pcs_pkg::PROD_W-1:0]    quot,
	output pcs_pkg::div_stat_t            stat
);
	import pcs_pkg::*;

	logic [DT_W-1:0]      rem_q;
	logic [PROD_W-1:0]    num_q;
	logic [DT_W-1:0]      den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DT_W-1:0]      rem_nxt;
	logic [PROD_W-1:0]    num_nxt;

	// restoring division, DIV_DIGIT one-bit steps per cycle while busy; quotient shifts into num_q
	always_comb begin
		logic [DT_W:0] t;
		rem_nxt = rem_q;
		num_nxt = num_q;
		for (int i = 0; i < DIV_DIGIT; i++) begin
			t = {rem_nxt, num_nxt[PROD_W-1]};
			num_nxt = {num_nxt[PROD_W-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				t = t - {1'b0, den_q};
				num_nxt[0] = 1'b1;
			end
			rem_nxt = t[DT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= numer;
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			num_q <= num_nxt;
		end
	end

	assign quot      = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> src/pcs_checker.sv
module pcs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [pcs_pkg::DATA_W-1:0] drive,
	input logic                              cfg_ready
);
	import pcs_pkg::*;

	// one word in flight: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again while a word is in flight");

	// a fresh result only ever appears as the sequencer finishes
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("drive word appeared without work in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive))
		else $error("stalled drive word changed or dropped");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> cfg_ready)
		else $error("configuration port blocked while idle");

endmodule

bind pid_controller_step_top pcs_checker u_pcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.drive     (drive),
	.cfg_ready (cfg_ready)
);
